[rtl/knob_controlled_sine_oscillator_core_assert.svh]
// Assertion macros shared by the oscillator RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef KNOB_CONTROLLED_SINE_OSCILLATOR_CORE_ASSERT_SVH
`define KNOB_CONTROLLED_SINE_OSCILLATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KCSO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KCSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/kcso_pkg.sv]
// Package for the knob-controlled sine oscillator: widths, register codes,
// shared types and the quarter-wave sine table. No dependencies.
package kcso_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int PHASE_BITS       = 32;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int ENTRY_W          = 16;
  localparam int AMP_W            = 18;
  localparam int LEVEL_W          = 16;
  localparam int STEP_W           = 32;
  localparam int WEIGHT_W         = 17;
  localparam int SAMPLE_W         = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  // Multiplier operand and product widths (signed).
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 19;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [AMP_W-1:0]    AMP_MAX     = 18'd131072;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 17'd65536;
  localparam logic [17:0]         LEVEL_FULL  = 18'd65535;
  localparam logic [17:0]         REM_MAX     = 18'd196605;

  localparam logic [31:0] STEP_AT_ZERO_RST  = 32'd9739155;
  localparam logic [31:0] STEP_SPAN_RST     = 32'd87652394;
  localparam logic [15:0] LEVEL_ZERO_RST    = 16'd8000;
  localparam logic [15:0] LEVEL_GAIN_RST    = 16'd8389;
  localparam logic [16:0] SMOOTH_WEIGHT_RST = 17'd3277;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_AT_ZERO  = 3'd0,
    REG_STEP_SPAN     = 3'd1,
    REG_LEVEL_ZERO    = 3'd2,
    REG_LEVEL_GAIN    = 3'd3,
    REG_SMOOTH_WEIGHT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_at_zero;
    logic [STEP_W-1:0]   step_span;
    logic [LEVEL_W-1:0]  level_zero;
    logic [LEVEL_W-1:0]  level_gain;
    logic [WEIGHT_W-1:0] smooth_weight;
  } cfg_t;

  // One classified tick waiting for the back end.
  typedef struct packed {
    logic               fresh;
    logic [LEVEL_W-1:0] freq;
    logic [LEVEL_W-1:0] ampl_ofs;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_STEP,
    BK_DIV,
    BK_FIX,
    BK_SMOOTH_MUL,
    BK_SMOOTH,
    BK_SINE_MUL,
    BK_EMIT
  } back_state_t;

  typedef logic [ENTRY_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

  // Quarter-wave table, Q30 Taylor series to the 11th power, rounded to Q15.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x    = (PI_Q30 * 64'(2 * i + 1)) / 64'(4 * SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      tab[i] = ENTRY_W'((sum * 64'd32767 + 64'd536870912) >> 30);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[rtl/knob_controlled_sine_oscillator_core.sv]
// Knob-controlled sine oscillator top: config registers, front end, queue, back end.
// Each tick runs the smooth multiply, smooth, sine multiply and emit states in turn; a fresh
// tick first runs the step multiply, level multiply and divide-correction steps. All share one
// multiplier. The next tick is popped as a result is emitted; a stalled output holds the back end.
// Reset (rst_n low at a clock edge): registers to defaults, phase/step/amplitudes zero, queue empty.
module knob_controlled_sine_oscillator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kcso_pkg::LEVEL_W-1:0]      in_freq_level,
  input  logic [kcso_pkg::LEVEL_W-1:0]      in_ampl_level,
  input  logic                              in_levels_fresh,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [kcso_pkg::SAMPLE_W-1:0] out_audio_sample,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kcso_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kcso_pkg::CFG_DATA_W-1:0]   cfg_data
);

  kcso_pkg::cfg_t            cfg_r;
  kcso_pkg::item_t           push_item;
  kcso_pkg::item_t           head_item;
  kcso_pkg::q_stat_t         q_stat;
  logic                      push;
  logic                      q_pop;
  logic [kcso_pkg::WEIGHT_W-1:0] wr_weight;
  logic [kcso_pkg::SAMPLE_W-1:0] sample;

  assign cfg_ready = 1'b1;
  assign wr_weight = cfg_data[kcso_pkg::WEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_at_zero  <= kcso_pkg::STEP_AT_ZERO_RST;
      cfg_r.step_span     <= kcso_pkg::STEP_SPAN_RST;
      cfg_r.level_zero    <= kcso_pkg::LEVEL_ZERO_RST;
      cfg_r.level_gain    <= kcso_pkg::LEVEL_GAIN_RST;
      cfg_r.smooth_weight <= kcso_pkg::SMOOTH_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kcso_pkg::REG_STEP_AT_ZERO:  cfg_r.step_at_zero <= cfg_data;
        kcso_pkg::REG_STEP_SPAN:     cfg_r.step_span    <= cfg_data;
        kcso_pkg::REG_LEVEL_ZERO:    cfg_r.level_zero   <= cfg_data[kcso_pkg::LEVEL_W-1:0];
        kcso_pkg::REG_LEVEL_GAIN:    cfg_r.level_gain   <= cfg_data[kcso_pkg::LEVEL_W-1:0];
        kcso_pkg::REG_SMOOTH_WEIGHT: begin
          // Hold the weight at 1.0 in Q16.
          cfg_r.smooth_weight <= (wr_weight > kcso_pkg::WEIGHT_MAX) ? kcso_pkg::WEIGHT_MAX
                                                                    : wr_weight;
        end
        default: ;
      endcase
    end
  end

  kcso_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_freq_level   (in_freq_level),
    .in_ampl_level   (in_ampl_level),
    .in_levels_fresh (in_levels_fresh),
    .level_zero      (cfg_r.level_zero),
    .q_stat          (q_stat),
    .push            (push),
    .push_item       (push_item)
  );

  kcso_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  kcso_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head_item        (head_item),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_audio_sample (sample)
  );

  assign out_audio_sample = $signed(sample);

endmodule

[rtl/kcso_queue.sv]
// Short item queue between the front and back ends of the oscillator.
// Depends on kcso_pkg for the item type, depth and status struct.
module kcso_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  kcso_pkg::item_t  push_item,
  input  logic             pop,
  output kcso_pkg::item_t  head_item,
  output kcso_pkg::q_stat_t stat
);

  kcso_pkg::item_t                   mem_r [kcso_pkg::QUEUE_DEPTH];
  logic [kcso_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [kcso_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [kcso_pkg::QCNT_W-1:0]       count_r;
  logic [kcso_pkg::QCNT_W-1:0]       count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + kcso_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - kcso_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + kcso_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + kcso_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item  = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == kcso_pkg::QCNT_W'(kcso_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

[rtl/kcso_front.sv]
// Front end: takes ticks from the input channel, offsets the amplitude level
// and pushes classified items into the queue. Depends on kcso_pkg.
module kcso_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kcso_pkg::LEVEL_W-1:0]  in_freq_level,
  input  logic [kcso_pkg::LEVEL_W-1:0]  in_ampl_level,
  input  logic                          in_levels_fresh,
  input  logic [kcso_pkg::LEVEL_W-1:0]  level_zero,
  input  kcso_pkg::q_stat_t             q_stat,
  output logic                          push,
  output kcso_pkg::item_t               push_item
);

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_item.fresh = in_levels_fresh;
    push_item.freq  = in_freq_level;
    // Clamp at zero below the zero point.
    if (in_ampl_level > level_zero) begin
      push_item.ampl_ofs = in_ampl_level - level_zero;
    end else begin
      push_item.ampl_ofs = '0;
    end
  end

endmodule

[rtl/kcso_back.sv]
// Back end: sequencer around one shared multiplier that maps controls,
// smooths amplitude, reads the sine table and holds the output register.
// Depends on kcso_pkg and the assertion macro header.
`include "knob_controlled_sine_oscillator_core_assert.svh"

module kcso_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kcso_pkg::cfg_t                 cfg,
  input  kcso_pkg::item_t                head_item,
  input  kcso_pkg::q_stat_t              q_stat,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kcso_pkg::SAMPLE_W-1:0]  out_audio_sample
);

  localparam int PB = kcso_pkg::PHASE_BITS;

  kcso_pkg::back_state_t state_r;
  kcso_pkg::back_state_t state_nxt;

  kcso_pkg::item_t                   item_r;
  logic [PB-1:0]                     phase_r;
  logic [PB-1:0]                     held_step_r;
  logic [kcso_pkg::AMP_W-1:0]        target_r;
  logic [kcso_pkg::AMP_W-1:0]        smoothed_r;
  logic [32:0]                       quot_r;
  logic [17:0]                       rem_r;
  logic [1:0]                        quad_r;
  logic [kcso_pkg::ENTRY_W-1:0]      entry_r;
  logic signed [kcso_pkg::MUL_P_W-1:0] prod_r;
  logic                              out_valid_r;
  logic [kcso_pkg::SAMPLE_W-1:0]     out_sample_r;

  logic                              out_free;
  logic                              out_load;
  logic                              mul_en;
  logic signed [kcso_pkg::MUL_A_W-1:0] mul_a;
  logic signed [kcso_pkg::MUL_B_W-1:0] mul_b;
  logic signed [kcso_pkg::MUL_P_W-1:0] mul_p;
  logic signed [18:0]                amp_diff;
  logic [32:0]                       quot_est;
  logic [17:0]                       rem_est;
  logic [19:0]                       target_raw;
  logic [31:0]                       step_sum;
  logic signed [kcso_pkg::MUL_P_W-1:0] smooth_acc;
  logic [35:0]                       smooth_q16;
  logic [kcso_pkg::SINE_IDX_W-1:0]   tab_idx;
  logic [36:0]                       mag_round;
  logic [20:0]                       mag;
  logic [16:0]                       mag_c;
  logic [kcso_pkg::SAMPLE_W-1:0]     sample;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_audio_sample = out_sample_r;

  // Next state, queue pop and output load.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      kcso_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = head_item.fresh ? kcso_pkg::BK_STEP : kcso_pkg::BK_SMOOTH_MUL;
        end
      end
      kcso_pkg::BK_STEP:       state_nxt = kcso_pkg::BK_DIV;
      kcso_pkg::BK_DIV:        state_nxt = kcso_pkg::BK_FIX;
      kcso_pkg::BK_FIX: begin
        if (rem_r < kcso_pkg::LEVEL_FULL) begin
          state_nxt = kcso_pkg::BK_SMOOTH_MUL;
        end
      end
      kcso_pkg::BK_SMOOTH_MUL: state_nxt = kcso_pkg::BK_SMOOTH;
      kcso_pkg::BK_SMOOTH:     state_nxt = kcso_pkg::BK_SINE_MUL;
      kcso_pkg::BK_SINE_MUL:   state_nxt = kcso_pkg::BK_EMIT;
      kcso_pkg::BK_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!q_stat.empty) begin
            q_pop     = 1'b1;
            state_nxt = head_item.fresh ? kcso_pkg::BK_STEP : kcso_pkg::BK_SMOOTH_MUL;
          end else begin
            state_nxt = kcso_pkg::BK_IDLE;
          end
        end
      end
      default: state_nxt = kcso_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kcso_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Shared multiplier operand selection.
  assign amp_diff = $signed({1'b0, target_r}) - $signed({1'b0, smoothed_r});

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      kcso_pkg::BK_STEP: begin
        mul_a = $signed({1'b0, cfg.step_span});
        mul_b = $signed({3'b000, item_r.freq});
      end
      kcso_pkg::BK_DIV: begin
        mul_a = $signed({17'd0, item_r.ampl_ofs});
        mul_b = $signed({3'b000, cfg.level_gain});
      end
      kcso_pkg::BK_SMOOTH_MUL: begin
        mul_a = $signed({{14{amp_diff[18]}}, amp_diff});
        mul_b = $signed({2'b00, cfg.smooth_weight});
      end
      kcso_pkg::BK_SINE_MUL: begin
        mul_a = $signed({15'd0, smoothed_r});
        mul_b = $signed({3'b000, entry_r});
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Divide by 65535: estimate from the 16-bit digits, then correct.
  assign quot_est = {1'b0, prod_r[47:16]} + {17'd0, prod_r[47:32]};
  assign rem_est  = {2'b00, prod_r[15:0]} + {2'b00, prod_r[31:16]} + {2'b00, prod_r[47:32]};

  assign target_raw = prod_r[31:12];
  assign step_sum   = cfg.step_at_zero + quot_r[31:0];

  // Smoothed = smoothed + (target - smoothed) * w, rounded in Q16.
  assign smooth_acc = $signed({18'd0, smoothed_r, 16'd0}) + prod_r
                      + $signed(kcso_pkg::MUL_P_W'(32768));
  assign smooth_q16 = smooth_acc[51:16];

  always_comb begin
    tab_idx = phase_r[PB-3 -: kcso_pkg::SINE_IDX_W];
    if (phase_r[PB-2]) begin
      tab_idx = ~tab_idx;
    end
  end

  assign mag_round = {1'b0, prod_r[35:0]} + 37'd32768;
  assign mag       = mag_round[36:16];

  always_comb begin
    if (quad_r[1]) begin
      mag_c  = (mag > 21'd32768) ? 17'd32768 : mag[16:0];
      sample = kcso_pkg::SAMPLE_W'(17'd0 - mag_c);
    end else begin
      mag_c  = (mag > 21'd32767) ? 17'd32767 : mag[16:0];
      sample = mag_c[kcso_pkg::SAMPLE_W-1:0];
    end
  end

  // Oscillator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      held_step_r <= '0;
      target_r    <= '0;
      smoothed_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == kcso_pkg::BK_FIX && rem_r < kcso_pkg::LEVEL_FULL) begin
        held_step_r <= step_sum[PB-1:0];
        target_r    <= (target_raw > 20'(kcso_pkg::AMP_MAX)) ? kcso_pkg::AMP_MAX
                                                             : target_raw[17:0];
      end
      if (state_r == kcso_pkg::BK_SMOOTH) begin
        smoothed_r <= (smooth_q16 > 36'(kcso_pkg::AMP_MAX)) ? kcso_pkg::AMP_MAX
                                                            : smooth_q16[17:0];
      end
      if (state_r == kcso_pkg::BK_SINE_MUL) begin
        phase_r <= phase_r + held_step_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= head_item;
    end
    if (mul_en) begin
      prod_r <= mul_p;
    end
    if (state_r == kcso_pkg::BK_DIV) begin
      quot_r <= quot_est;
      rem_r  <= rem_est;
    end else if (state_r == kcso_pkg::BK_FIX && rem_r >= kcso_pkg::LEVEL_FULL) begin
      quot_r <= quot_r + 33'd1;
      rem_r  <= rem_r - kcso_pkg::LEVEL_FULL;
    end
    if (state_r == kcso_pkg::BK_SMOOTH) begin
      quad_r  <= phase_r[PB-1 -: 2];
      entry_r <= kcso_pkg::SINE_TAB[tab_idx];
    end
    if (out_load) begin
      out_sample_r <= sample;
    end
  end

  `KCSO_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")
  `KCSO_ASSERT_NOW(a_amp_cap, 1'b1,
    (target_r <= kcso_pkg::AMP_MAX) && (smoothed_r <= kcso_pkg::AMP_MAX),
    "amplitude above saturation")
  `KCSO_ASSERT_NOW(a_rem_bound, state_r == kcso_pkg::BK_FIX,
    rem_r <= kcso_pkg::REM_MAX, "divide remainder out of range")
  `KCSO_ASSERT_NEXT(a_phase_hold, state_r != kcso_pkg::BK_SINE_MUL,
    $stable(phase_r), "phase moved outside its update step")
  `KCSO_ASSERT_NEXT(a_emit_wait,
    (state_r == kcso_pkg::BK_EMIT) && out_valid_r && out_stall,
    state_r == kcso_pkg::BK_EMIT, "result dropped while output stalled")

endmodule

[test/tb_top.sv]
// Testbench for knob_controlled_sine_oscillator_core: a directed table of ticks and register
// writes, then random phases. Each audio sample is checked against an oscillator predictor
// in this file or, on known rows, the typed sample. Depends on kcso_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kcso_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RAND_PHASES     = 7;
  localparam int TICKS_PER_PHASE = 100;
  localparam int PRINT_CAP       = 20;
  localparam int REG_COUNT       = int'(REG_SMOOTH_WEIGHT) + 1;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_LIST = CFG_IDX_W'(REG_COUNT);

  // Register settings of the random phases.
  localparam int PH_ALL_ZERO  = 0;
  localparam int PH_ALL_ONES  = 1;
  localparam int PH_RESET_SET = 2;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [LEVEL_W-1:0]         freq;
    logic [LEVEL_W-1:0]         ampl;
    logic                       fresh;
    logic                       known;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CFG_IDX_W-1:0]       reg_idx;
    logic [CFG_DATA_W-1:0]      reg_data;
  } script_row_t;

  localparam int SCRIPT_ROWS = 30;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // silence after reset, levels below and at the zero point
    '{kind: ROW_TICK, freq: 16'h0000, ampl: 16'h0000, fresh: 1'b0, known: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'h0000, ampl: 16'h0000, fresh: 1'b1, known: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'hFFFF, ampl: 16'd8000, fresh: 1'b1, known: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'hFFFF, ampl: 16'd8001, fresh: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'h0000, ampl: 16'hFFFF, fresh: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'h1234, ampl: 16'h0000, fresh: 1'b0, default: '0},
    '{kind: ROW_TICK, freq: 16'hAAAA, ampl: 16'h5555, fresh: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'h5555, ampl: 16'hAAAA, fresh: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'hFFFF, ampl: 16'hFFFF, fresh: 1'b0, default: '0},
    // masked data, clamped weight, quarter-turn step, write past the register list
    '{kind: ROW_WRITE, reg_idx: REG_LEVEL_ZERO, reg_data: 32'hFFFF_0000, default: '0},
    '{kind: ROW_WRITE, reg_idx: REG_LEVEL_GAIN, reg_data: 32'h1234_FFFF, default: '0},
    '{kind: ROW_WRITE, reg_idx: REG_SMOOTH_WEIGHT, reg_data: 32'hFFFF_FFFF, default: '0},
    '{kind: ROW_WRITE, reg_idx: REG_STEP_AT_ZERO, reg_data: 32'h4000_0000, default: '0},
    '{kind: ROW_WRITE, reg_idx: REG_STEP_SPAN, reg_data: 32'h0000_0000, default: '0},
    '{kind: ROW_WRITE, reg_idx: REG_PAST_LIST, reg_data: 32'hFFFF_FFFF, default: '0},
    // amplitude past 2.0, then all four quadrants: samples saturate both ways
    '{kind: ROW_TICK, freq: 16'h8000, ampl: 16'hFFFF, fresh: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'h0000, ampl: 16'h0000, fresh: 1'b0, default: '0},
    '{kind: ROW_TICK, freq: 16'hFFFF, ampl: 16'h0000, fresh: 1'b0, default: '0},
    '{kind: ROW_TICK, freq: 16'h0000, ampl: 16'hFFFF, fresh: 1'b0, default: '0},
    '{kind: ROW_TICK, freq: 16'h7FFF, ampl: 16'h8000, fresh: 1'b0, default: '0},
    // zero weight freezes the amplitude
    '{kind: ROW_WRITE, reg_idx: REG_SMOOTH_WEIGHT, reg_data: 32'd0, default: '0},
    '{kind: ROW_TICK, freq: 16'h0000, ampl: 16'h0000, fresh: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'h0000, ampl: 16'h0000, fresh: 1'b0, default: '0},
    // full weight takes the target at once; the step sum wraps
    '{kind: ROW_WRITE, reg_idx: REG_SMOOTH_WEIGHT, reg_data: 32'd65536, default: '0},
    '{kind: ROW_WRITE, reg_idx: REG_STEP_AT_ZERO, reg_data: 32'hFFFF_FFFF, default: '0},
    '{kind: ROW_WRITE, reg_idx: REG_STEP_SPAN, reg_data: 32'hFFFF_FFFF, default: '0},
    '{kind: ROW_TICK, freq: 16'hFFFF, ampl: 16'h0000, fresh: 1'b1, known: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'h0001, ampl: 16'hFFFF, fresh: 1'b1, default: '0},
    '{kind: ROW_TICK, freq: 16'h0000, ampl: 16'h7FFF, fresh: 1'b0, default: '0},
    '{kind: ROW_TICK, freq: 16'h8000, ampl: 16'h0001, fresh: 1'b1, default: '0}
  };

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [LEVEL_W-1:0]         in_freq_level;
  logic [LEVEL_W-1:0]         in_ampl_level;
  logic                       in_levels_fresh;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_audio_sample;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  // Oscillator predictor: register copy and state.
  cfg_t                 osc_cfg;
  logic [PHASE_BITS-1:0] osc_phase;
  logic [PHASE_BITS-1:0] osc_step;
  logic [AMP_W-1:0]      osc_target;
  logic [AMP_W-1:0]      osc_level;
  logic [ENTRY_W-1:0]    quarter_wave [SINE_TABLE_DEPTH];

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  logic signed [SAMPLE_W-1:0] want_sample;
  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_pct = 30;
  bit calm = 1'b0;

  knob_controlled_sine_oscillator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_freq_level    (in_freq_level),
    .in_ampl_level    (in_ampl_level),
    .in_levels_fresh  (in_levels_fresh),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_audio_sample (out_audio_sample),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Quarter sine by a Q30 Taylor series up to the 11th power, rounded to Q15.
  function automatic void fill_quarter_wave();
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x    = (PI_Q30 * 64'(2 * i + 1)) / 64'(4 * SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 5; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        sum  = (k % 2 == 1) ? sum - term : sum + term;
      end
      quarter_wave[i] = ENTRY_W'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
    end
  endfunction

  function automatic void reset_oscillator();
    osc_cfg.step_at_zero  = STEP_AT_ZERO_RST;
    osc_cfg.step_span     = STEP_SPAN_RST;
    osc_cfg.level_zero    = LEVEL_ZERO_RST;
    osc_cfg.level_gain    = LEVEL_GAIN_RST;
    osc_cfg.smooth_weight = SMOOTH_WEIGHT_RST;
    osc_phase  = '0;
    osc_step   = '0;
    osc_target = '0;
    osc_level  = '0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_STEP_AT_ZERO:  osc_cfg.step_at_zero = data[STEP_W-1:0];
      REG_STEP_SPAN:     osc_cfg.step_span = data[STEP_W-1:0];
      REG_LEVEL_ZERO:    osc_cfg.level_zero = data[LEVEL_W-1:0];
      REG_LEVEL_GAIN:    osc_cfg.level_gain = data[LEVEL_W-1:0];
      REG_SMOOTH_WEIGHT: begin
        osc_cfg.smooth_weight = (data[WEIGHT_W-1:0] > WEIGHT_MAX) ? WEIGHT_MAX
                                                                  : data[WEIGHT_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // One audio tick: returns the sample and advances the predictor state.
  function automatic logic signed [SAMPLE_W-1:0] advance_oscillator(
    input logic [LEVEL_W-1:0] freq,
    input logic [LEVEL_W-1:0] ampl,
    input logic               fresh
  );
    logic [63:0]                prod;
    logic [63:0]                mag;
    logic [63:0]                idx;
    logic [1:0]                 quad;
    logic signed [SAMPLE_W-1:0] sample;
    if (fresh) begin
      prod     = 64'(osc_cfg.step_span) * 64'(freq);
      osc_step = PHASE_BITS'(64'(osc_cfg.step_at_zero) + prod / 64'd65535);
      if (ampl > osc_cfg.level_zero) begin
        prod       = (64'(ampl - osc_cfg.level_zero) * 64'(osc_cfg.level_gain)) >> 12;
        osc_target = (prod > 64'(AMP_MAX)) ? AMP_MAX : AMP_W'(prod);
      end else begin
        osc_target = '0;
      end
    end
    prod = 64'(osc_target) * 64'(osc_cfg.smooth_weight)
         + 64'(osc_level) * (64'(WEIGHT_MAX) - 64'(osc_cfg.smooth_weight)) + 64'd32768;
    prod = prod >> 16;
    osc_level = (prod > 64'(AMP_MAX)) ? AMP_MAX : AMP_W'(prod);

    quad = osc_phase[PHASE_BITS-1 -: 2];
    idx  = (64'(osc_phase[PHASE_BITS-3:0]) * 64'(SINE_TABLE_DEPTH)) >> (PHASE_BITS - 2);
    // odd quadrants run the table backward
    if (quad[0]) idx = 64'(SINE_TABLE_DEPTH - 1) - idx;
    mag = (64'(osc_level) * 64'(quarter_wave[idx]) + 64'd32768) >> 16;
    if (quad[1]) begin
      if (mag > 64'd32768) mag = 64'd32768;
      sample = SAMPLE_W'(-mag);
    end else begin
      if (mag > 64'd32767) mag = 64'd32767;
      sample = SAMPLE_W'(mag);
    end
    osc_phase = osc_phase + osc_step;
    return sample;
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 99) >= idle_pct) return 0;
    return $urandom_range(1, 7);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("%0t ns: %s", $time, what);
  endtask

  task automatic send_tick(input logic [LEVEL_W-1:0]         freq,
                           input logic [LEVEL_W-1:0]         ampl,
                           input logic                       fresh,
                           input logic                       known,
                           input logic signed [SAMPLE_W-1:0] typed);
    int                         gap;
    logic signed [SAMPLE_W-1:0] predicted;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_freq_level   <= freq;
    in_ampl_level   <= ampl;
    in_levels_fresh <= fresh;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_oscillator(freq, ampl, fresh);
    expected_samples.push_back(known ? typed : predicted);
  endtask

  // Drop valid and hold until every sample is out and the core has gone quiet.
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_phase(input int ph);
    logic [CFG_DATA_W-1:0] vals [REG_COUNT];
    case (ph)
      PH_ALL_ZERO: begin
        foreach (vals[r]) vals[r] = '0;
      end
      PH_ALL_ONES: begin
        foreach (vals[r]) vals[r] = '1;
      end
      PH_RESET_SET: begin
        vals[REG_STEP_AT_ZERO]  = STEP_AT_ZERO_RST;
        vals[REG_STEP_SPAN]     = STEP_SPAN_RST;
        vals[REG_LEVEL_ZERO]    = CFG_DATA_W'(LEVEL_ZERO_RST);
        vals[REG_LEVEL_GAIN]    = CFG_DATA_W'(LEVEL_GAIN_RST);
        vals[REG_SMOOTH_WEIGHT] = CFG_DATA_W'(SMOOTH_WEIGHT_RST);
      end
      default: begin
        vals[REG_STEP_AT_ZERO] = $urandom;
        vals[REG_STEP_SPAN]    = $urandom;
        vals[REG_LEVEL_ZERO]   = $urandom_range(0, 1) ? $urandom_range(0, 12000) : $urandom;
        vals[REG_LEVEL_GAIN]   = $urandom;
        case ($urandom_range(0, 2))
          0: vals[REG_SMOOTH_WEIGHT] = $urandom_range(1, 4000);
          1: vals[REG_SMOOTH_WEIGHT] = $urandom_range(0, 65536);
          default: vals[REG_SMOOTH_WEIGHT] = $urandom;
        endcase
      end
    endcase
    for (int r = 0; r < REG_COUNT; r++) write_reg(CFG_IDX_W'(r), vals[r]);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2 ** CFG_IDX_W - 1)), $urandom);
    end
  endtask

  // Receiver back-pressure in bursts; none once the run has gone calm.
  initial begin : receiver_stall
    int stall_left;
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !calm) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("audio_sample %0d with no tick pending", out_audio_sample));
      end else begin
        want_sample = expected_samples.pop_front();
        if (out_audio_sample !== want_sample) begin
          report_mismatch($sformatf("audio_sample %0d, expected %0d",
                                    out_audio_sample, want_sample));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL knob_controlled_sine_oscillator_core");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_freq_level   = '0;
    in_ampl_level   = '0;
    in_levels_fresh = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_STEP_AT_ZERO;
    cfg_data        = '0;
    fill_quarter_wave();
    reset_oscillator();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].kind == ROW_WRITE) begin
        settle_idle();
        write_reg(SCRIPT[r].reg_idx, SCRIPT[r].reg_data);
      end else begin
        send_tick(SCRIPT[r].freq, SCRIPT[r].ampl, SCRIPT[r].fresh,
                  SCRIPT[r].known, SCRIPT[r].sample);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_idle();
      program_phase(ph);
      idle_pct = (ph % 3 == 1) ? 0 : $urandom_range(15, 50);
      calm     = (ph == RAND_PHASES - 1);
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        // now and then hold off until the pipeline has drained
        if (!calm && $urandom_range(0, 59) == 0) settle_idle();
        send_tick(pick_level(), pick_level(), $urandom_range(0, 3) == 0, 1'b0, '0);
      end
    end

    settle_idle();
    if (mismatch_count == 0) begin
      $display("PASS knob_controlled_sine_oscillator_core");
    end else begin
      $display("FAIL knob_controlled_sine_oscillator_core");
    end
    $finish;
  end

endmodule
